/* hdl/bayer_demosaic_window_macros.svh */
// Assertion macros for the demosaic window block.
`ifndef BAYER_DEMOSAIC_WINDOW_MACROS_SVH
`define BAYER_DEMOSAIC_WINDOW_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bdw_pkg.sv */
`timescale 1ns / 1ps

package bdw_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  localparam int FW_W  = 12;
  localparam int FH_W  = 13;
  localparam int CFG_W = 13;
  localparam int PIX_W = 8;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_X_ODD = 2'd2;
  localparam logic [1:0] CFG_ORIGIN_Y_ODD = 2'd3;

  // Block position codes: P00, P10, P01, P11.
  localparam logic [1:0] POS_RED  [4] = '{2'd0, 2'd2, 2'd2, 2'd3};
  localparam logic [1:0] POS_G1   [4] = '{2'd1, 2'd0, 2'd3, 2'd2};
  localparam logic [1:0] POS_G2   [4] = '{2'd2, 2'd3, 2'd0, 2'd1};
  localparam logic [1:0] POS_BLUE [4] = '{2'd3, 2'd1, 2'd1, 2'd0};

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             run_last;
    logic             frame_last;
  } result_t;

  // Results offered by the pixel stage to the output buffer.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t bdw_color(input logic [1:0] sel,
                                        input logic [3:0][PIX_W-1:0] blk);
    result_t    res;
    logic [PIX_W:0] sum;
    begin
      sum            = {1'b0, blk[POS_G1[sel]]} + {1'b0, blk[POS_G2[sel]]};
      res.red        = blk[POS_RED[sel]];
      res.green      = sum[PIX_W:1];
      res.blue       = blk[POS_BLUE[sel]];
      res.run_last   = 1'b0;
      res.frame_last = 1'b0;
      return res;
    end
  endfunction

endpackage

/* hdl/bdw_line_ram.sv */
`timescale 1ns / 1ps

module bdw_line_ram #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Read the old entry, then overwrite it.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

/* hdl/bdw_out_buf.sv */
`timescale 1ns / 1ps

module bdw_out_buf
  import bdw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t head
);

  logic [1:0] count;
  logic [1:0] count_next;
  result_t    slot [2];
  result_t    slot_next [2];
  logic       pop;
  logic [1:0] base;

  always_comb begin
    pop          = (count != 2'd0) && result_ready;
    base         = count - {1'b0, pop};
    room         = ({1'b0, 2'd2 - base}) >= {1'b0, push.count};
    slot_next[0] = pop ? slot[1] : slot[0];
    slot_next[1] = slot[1];
    count_next   = base;
    if (room) begin
      count_next = base + push.count;
      if (push.count != 2'd0) begin
        if (base == 2'd0) begin
          slot_next[0] = push.first;
        end else begin
          slot_next[1] = push.first;
        end
      end
      if (push.count == 2'd2) begin
        slot_next[1] = push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot[0] <= slot_next[0];
    slot[1] <= slot_next[1];
  end

  assign result_valid = (count != 2'd0);
  assign head         = slot[0];

endmodule

/* hdl/bayer_demosaic_window.sv */
`timescale 1ns / 1ps
// Channel  | Handshake                   | Payload
// pixel    | pixel_valid / pixel_ready   | action, pixel
// result   | result_valid / result_ready | red, green, blue, run_last, frame_last
// config   | write_enable                | register_index, write_data
//
// One pixel item per cycle while the pixel stage is free to advance; each item first visits the line buffer port
// (read old sample, write new one), then forms its results in the pixel stage.
// An item yields 0, 1 or 2 results; the two-slot output buffer absorbs the
// extra result at the right edge of a row.
// Reset (rst, synchronous) clears counters, neighbor registers and buffers;
// the line buffer needs no clearing.
// A stalled result side stops the pixel stage, which then drops pixel_ready.

module bayer_demosaic_window
  import bdw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  logic             action,
  input  logic [PIX_W-1:0] pixel,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [PIX_W-1:0] red,
  output logic [PIX_W-1:0] green,
  output logic [PIX_W-1:0] blue,
  output logic             run_last,
  output logic             frame_last,
  input  logic             write_enable,
  input  logic [1:0]       register_index,
  input  logic [CFG_W-1:0] write_data
);

`include "bayer_demosaic_window_macros.svh"

  // Configuration registers.
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            origin_x_odd;
  logic            origin_y_odd;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(640);
      frame_height <= FH_W'(640);
      origin_x_odd <= 1'b0;
      origin_y_odd <= 1'b0;
    end else if (write_enable) begin
      case (register_index)
        CFG_FRAME_WIDTH:  frame_width  <= write_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= write_data[FH_W-1:0];
        CFG_ORIGIN_X_ODD: origin_x_odd <= write_data[0];
        CFG_ORIGIN_Y_ODD: origin_y_odd <= write_data[0];
        default: ;
      endcase
    end
  end

  // Front stage: position counters and line buffer access.
  logic [COL_W-1:0] col_index;
  logic [FH_W-1:0]  row_index;
  logic [FW_W-1:0]  width_eff;
  logic [FH_W-1:0]  height_eff;
  logic [COL_W-1:0] last_col;
  logic [COL_W-1:0] col_cur;
  logic [FH_W-1:0]  row_cur;
  logic [PIX_W-1:0] pix_eff;
  logic             row_end;
  logic             accept;

  always_comb begin
    if (frame_width == '0) begin
      width_eff = FW_W'(1);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      width_eff = FW_W'(MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    height_eff = (frame_height == '0) ? FH_W'(1) : frame_height;
    last_col   = COL_W'(width_eff - FW_W'(1));
    col_cur    = (FW_W'(col_index) >= width_eff) ? last_col : col_index;
    row_cur    = (row_index > height_eff) ? height_eff : row_index;
    // Pad ticks and the flush row read as zero samples.
    pix_eff    = (action || (row_cur >= height_eff)) ? '0 : pixel;
    row_end    = (col_cur == last_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      row_index <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_index <= '0;
        row_index <= (row_cur >= height_eff) ? '0 : row_cur + FH_W'(1);
      end else begin
        col_index <= col_cur + COL_W'(1);
        row_index <= row_cur;
      end
    end
  end

  logic [PIX_W-1:0] above;

  bdw_line_ram #(
    .DEPTH (MAX_WIDTH),
    .DATA_W(PIX_W)
  ) u_line_ram (
    .clk  (clk),
    .en   (accept),
    .addr (col_cur),
    .wdata(pix_eff),
    .rdata(above)
  );

  // Pixel stage: holds one item together with its line buffer sample.
  logic             valid1;
  logic [PIX_W-1:0] p1;
  logic             has_a1;
  logic             has_b1;
  logic             row_end1;
  logic             frame1;
  logic [1:0]       sel_a1;
  logic [1:0]       sel_b1;
  logic [PIX_W-1:0] left_current;
  logic [PIX_W-1:0] left_above;
  logic             room;
  logic             adv1;
  logic             y_par;

  assign y_par       = ~row_cur[0] ^ origin_y_odd;
  assign adv1        = valid1 && room;
  assign pixel_ready = !valid1 || room;
  assign accept      = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (accept) begin
      valid1 <= 1'b1;
    end else if (adv1) begin
      valid1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1       <= pix_eff;
      has_a1   <= (row_cur != '0) && (col_cur != '0);
      has_b1   <= (row_cur != '0) && row_end;
      row_end1 <= row_end;
      frame1   <= (row_cur == height_eff);
      sel_a1   <= {y_par, ~col_cur[0] ^ origin_x_odd};
      sel_b1   <= {y_par, col_cur[0] ^ origin_x_odd};
    end
  end

  // Advance the left neighbors as each item leaves the pixel stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_current <= '0;
      left_above   <= '0;
    end else if (adv1) begin
      left_current <= p1;
      left_above   <= above;
    end
  end

  result_t res_a;
  result_t res_b;
  push_t   push;

  always_comb begin
    res_a            = bdw_color(sel_a1, {p1, left_current, above, left_above});
    res_a.run_last   = !row_end1;
    res_a.frame_last = 1'b0;
    // Right edge: samples right of the window read as zero.
    res_b            = bdw_color(sel_b1, {PIX_W'(0), p1, PIX_W'(0), above});
    res_b.run_last   = 1'b1;
    res_b.frame_last = frame1;
    push.count       = valid1 ? ({1'b0, has_a1} + {1'b0, has_b1}) : 2'd0;
    push.first       = has_a1 ? res_a : res_b;
    push.second      = res_b;
  end

  result_t head;

  bdw_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .head        (head)
  );

  assign red        = head.red;
  assign green      = head.green;
  assign blue       = head.blue;
  assign run_last   = head.run_last;
  assign frame_last = head.frame_last;

  `BDW_ASSERT_NOW(a_frame_last_ends_run, result_valid && frame_last, run_last,
                  "frame_last result without run_last")
  `BDW_ASSERT_NEXT(a_stall_holds_above, valid1 && !adv1, $stable(above),
                   "line buffer sample changed under a stalled item")
  `BDW_ASSERT_NOW(a_pair_only_at_edge, push.count == 2'd2, has_a1 && row_end1,
                  "two results pushed away from the row end")

endmodule
